/* src/pslp_pkg.sv */
// ----------------------------------------------------------------------------
// pslp_pkg
// Shared types and constants for the pedal short/long press detector.
// ----------------------------------------------------------------------------
package pslp_pkg;

  localparam int unsigned SampleW  = 8;
  localparam int unsigned ElapsedW = 10;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TimerW-1:0]  TimerMax      = '1;
  localparam logic [SampleW-1:0] PressThrRst   = 8'd100;
  localparam logic [SampleW-1:0] ReleaseThrRst = 8'd90;
  localparam logic [TimerW-1:0]  LongPressRst  = 16'd500;

  // Result codes on key_event
  localparam logic KeyPageDown = 1'b0;
  localparam logic KeyPageUp   = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESS_THR   = 2'd0,
    CFG_RELEASE_THR = 2'd1,
    CFG_LONG_PRESS  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] press_thr;
    logic [SampleW-1:0] release_thr;
    logic [TimerW-1:0]  long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic emit;
    logic key_event;
  } result_t;

endpackage

/* src/pslp_core.sv */
// ----------------------------------------------------------------------------
// pslp_core
// Hold state and per-sample press/release decision with long-press timer.
// ----------------------------------------------------------------------------
module pslp_core
  import pslp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [SampleW-1:0]  pedal_sample_i,
  input  logic                link_connected_i,
  input  logic [ElapsedW-1:0] elapsed_ms_i,
  input  cfg_t                cfg_i,
  output result_t             result_o
);

  logic              held_q, held_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic              long_rep_q, long_rep_d;

  logic [TimerW:0]   timer_sum;
  logic [TimerW-1:0] timer_adv;

  assign timer_sum = {1'b0, timer_q} + {{(TimerW+1-ElapsedW){1'b0}}, elapsed_ms_i};
  // saturate the hold timer at its top value
  assign timer_adv = timer_sum[TimerW] ? TimerMax : timer_sum[TimerW-1:0];

  always_comb begin
    held_d     = held_q;
    timer_d    = held_q ? timer_adv : timer_q;
    long_rep_d = long_rep_q;
    result_o   = '{emit: 1'b0, key_event: KeyPageDown};

    if (link_connected_i) begin
      priority if (!held_q && (pedal_sample_i > cfg_i.press_thr)) begin
        held_d     = 1'b1;
        timer_d    = '0;
        long_rep_d = 1'b0;
      end else if (held_q && (pedal_sample_i < cfg_i.release_thr)) begin
        if (!long_rep_q && (timer_d != '0) && (timer_d < cfg_i.long_press_ms)) begin
          result_o = '{emit: 1'b1, key_event: KeyPageDown};
        end
        held_d = 1'b0;
      end else begin
        held_d = held_q;
      end

      if (held_d && !long_rep_d && (timer_d >= cfg_i.long_press_ms)) begin
        result_o   = '{emit: 1'b1, key_event: KeyPageUp};
        long_rep_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= 1'b0;
      timer_q    <= '0;
      long_rep_q <= 1'b0;
    end else if (step_i) begin
      held_q     <= held_d;
      timer_q    <= timer_d;
      long_rep_q <= long_rep_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_page_up_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.emit && (result_o.key_event == KeyPageUp) |=> long_rep_q && held_q)
    else $error("page up without long press marked");

  a_page_down_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.emit && (result_o.key_event == KeyPageDown) |=> !held_q)
    else $error("page down while pedal still held");

  a_no_event_unlinked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !link_connected_i |-> !result_o.emit)
    else $error("event while link is down");

  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(timer_q) && $stable(held_q))
    else $error("state moved without a sample");
`endif

endmodule

/* src/pedal_short_long_press_detector.sv */
// ----------------------------------------------------------------------------
// pedal_short_long_press_detector
// Hysteresis press qualifier with short/long press key events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one pedal poll per beat:
//   sample, link flag and ms elapsed since the previous poll.
//   Output channel (out_valid_o / out_stall_i) carries key_event beats:
//   0 = page down (short press), 1 = page up (long press). A poll yields
//   zero or one beat.
//   A poll accepted into the input register is evaluated from that register
//   and its event sits in the output register once registered there.
//   Throughput: one poll per cycle unless the receiver stalls with an event
//   pending; the compare/add path between the input register and the output register is combinational.
//   When the receiver stalls with an event pending, the input register holds
//   its poll and in_stall_o rises once that register is full; polls resume
//   the cycle the pending beat is taken.
//   Config: cfg_we_i writes register cfg_idx_i (0 press threshold,
//   1 release threshold, 2 long press ms) from cfg_wdata_i; write only
//   while idle. Unknown indexes are dropped.
//   Reset: thresholds 100/90, long press 500 ms, pedal up, timer cleared,
//   both registers empty. The block accepts polls in the first cycle.
// ----------------------------------------------------------------------------
module pedal_short_long_press_detector
  import pslp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SampleW-1:0]  pedal_sample_i,
  input  logic                link_connected_i,
  input  logic [ElapsedW-1:0] elapsed_ms_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                key_event_o
);

  cfg_t cfg_q;

  logic                s_valid_q;
  logic [SampleW-1:0]  s_sample_q;
  logic                s_link_q;
  logic [ElapsedW-1:0] s_elapsed_q;

  logic    out_valid_q;
  logic    key_event_q;
  logic    out_free;
  logic    step;
  result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{press_thr: PressThrRst, release_thr: ReleaseThrRst,
                 long_press_ms: LongPressRst};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRESS_THR:   cfg_q.press_thr     <= cfg_wdata_i[SampleW-1:0];
        CFG_RELEASE_THR: cfg_q.release_thr   <= cfg_wdata_i[SampleW-1:0];
        CFG_LONG_PRESS:  cfg_q.long_press_ms <= cfg_wdata_i[TimerW-1:0];
        default:         cfg_q               <= cfg_q;
      endcase
    end
  end

  // output slot can take a new beat when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s_valid_q && out_free;
  assign in_stall_o = s_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s_sample_q  <= pedal_sample_i;
      s_link_q    <= link_connected_i;
      s_elapsed_q <= elapsed_ms_i;
    end
  end

  pslp_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .pedal_sample_i   (s_sample_q),
    .link_connected_i (s_link_q),
    .elapsed_ms_i     (s_elapsed_q),
    .cfg_i            (cfg_q),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && result.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && result.emit) begin
      key_event_q <= result.key_event;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_event_o = key_event_q;

endmodule

/* sim/pedal_short_long_press_detector_test.sv */
// ----------------------------------------------------------------------------
// pedal_short_long_press_detector_test
// Drives pedal polls and several register settings into the press detector,
// predicts the page-down/page-up key events per poll and compares every
// output beat in order against the predicted events.
// ----------------------------------------------------------------------------
module pedal_short_long_press_detector_test;
  import pslp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit    = 300000;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned DrainCycles   = 4;

  // Predicts key events from accepted polls and checks the output beats.
  class key_event_scoreboard;
    cfg_t              cfg;
    logic              held;
    logic [TimerW-1:0] hold_ms;
    logic              long_sent;
    logic              expected_keys[$];
    int unsigned       errors;

    function new();
      cfg.press_thr     = PressThrRst;
      cfg.release_thr   = ReleaseThrRst;
      cfg.long_press_ms = LongPressRst;
      held      = 1'b0;
      hold_ms   = '0;
      long_sent = 1'b0;
      errors    = 0;
    endfunction

    function void set_cfg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_PRESS_THR:   cfg.press_thr     = val[SampleW-1:0];
        CFG_RELEASE_THR: cfg.release_thr   = val[SampleW-1:0];
        CFG_LONG_PRESS:  cfg.long_press_ms = val[TimerW-1:0];
        default: ;
      endcase
    endfunction

    function void note_poll(logic [SampleW-1:0] sample, logic linked,
                            logic [ElapsedW-1:0] elapsed);
      logic [TimerW:0] sum;
      if (held) begin
        sum = {1'b0, hold_ms} + {{(TimerW+1-ElapsedW){1'b0}}, elapsed};
        hold_ms = sum[TimerW] ? TimerMax : sum[TimerW-1:0];
      end
      if (!linked) return;
      if (!held && sample > cfg.press_thr) begin
        held      = 1'b1;
        hold_ms   = '0;
        long_sent = 1'b0;
      end else if (held && sample < cfg.release_thr) begin
        if (!long_sent && hold_ms != 0 && hold_ms < cfg.long_press_ms)
          expected_keys.push_back(KeyPageDown);
        held = 1'b0;
      end
      if (held && !long_sent && hold_ms >= cfg.long_press_ms) begin
        expected_keys.push_back(KeyPageUp);
        long_sent = 1'b1;
      end
    endfunction

    function void check_key_event(logic actual);
      logic want;
      if (expected_keys.size() == 0) begin
        $error("key_event: expected none, actual %0d", actual);
        errors++;
        return;
      end
      want = expected_keys.pop_front();
      if (actual !== want) begin
        $error("key_event: expected %0d, actual %0d", want, actual);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_keys.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SampleW-1:0]  pedal_sample_i;
  logic                link_connected_i;
  logic [ElapsedW-1:0] elapsed_ms_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                key_event_o;

  key_event_scoreboard sb = new();

  bit          no_idle  = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned polls_sent = 0;
  int unsigned cycles     = 0;

  pedal_short_long_press_detector u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pedal_sample_i   (pedal_sample_i),
    .link_connected_i (link_connected_i),
    .elapsed_ms_i     (elapsed_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .key_event_o      (key_event_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** pedal_short_long_press_detector: FAILED **");
      $finish;
    end
  end

  // Check the output beat first: a poll taken at this edge cannot answer here.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_key_event(key_event_o);
      if (in_valid_i && !in_stall_o)
        sb.note_poll(pedal_sample_i, link_connected_i, elapsed_ms_i);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= !no_idle && ($urandom_range(99) < 14);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_poll(logic [SampleW-1:0] sample, logic linked,
                           logic [ElapsedW-1:0] elapsed);
    while (!no_idle && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    pedal_sample_i   <= sample;
    link_connected_i <= linked;
    elapsed_ms_i     <= elapsed;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    polls_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    sb.set_cfg(idx, val);
  endtask

  task automatic apply_settings(logic [SampleW-1:0] press, logic [SampleW-1:0] rel,
                                logic [TimerW-1:0] long_ms);
    drain();
    write_cfg(CFG_PRESS_THR, CfgDataW'(press));
    write_cfg(CFG_RELEASE_THR, CfgDataW'(rel));
    write_cfg(CFG_LONG_PRESS, long_ms);
  endtask

  function automatic logic [SampleW-1:0] press_sample();
    if (sb.cfg.press_thr == '1) return '1;
    return SampleW'($urandom_range(int'(sb.cfg.press_thr) + 1, 255));
  endfunction

  function automatic logic [SampleW-1:0] release_sample();
    if (sb.cfg.release_thr == '0) return '0;
    return SampleW'($urandom_range(0, int'(sb.cfg.release_thr) - 1));
  endfunction

  // Mostly stay at or above the release threshold; now and then drop early.
  function automatic logic [SampleW-1:0] hold_sample();
    if ($urandom_range(7) == 0) return SampleW'($urandom_range(255));
    return SampleW'($urandom_range(int'(sb.cfg.release_thr), 255));
  endfunction

  // Press, a few held polls, release; short or long steps at random.
  task automatic gesture();
    int unsigned holds;
    int unsigned max_step;
    holds    = $urandom_range(0, 6);
    max_step = $urandom_range(1) ? 1023 : $urandom_range(1, 40);
    send_poll(press_sample(), 1'b1, ElapsedW'($urandom_range(1023)));
    repeat (holds)
      send_poll(hold_sample(), $urandom_range(9) != 0, ElapsedW'($urandom_range(max_step)));
    send_poll(release_sample(), 1'b1, ElapsedW'($urandom_range(max_step)));
  endtask

  task automatic random_polls(int unsigned until_count);
    while (polls_sent < until_count) begin
      if ($urandom_range(9) < 7) gesture();
      else send_poll(SampleW'($urandom_range(255)), 1'(($urandom_range(1))),
                     ElapsedW'($urandom_range(1023)));
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_PRESS_THR;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    pedal_sample_i   = '0;
    link_connected_i = 1'b0;
    elapsed_ms_i     = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: 100 / 90 / 500 ms.
    send_poll(8'd255, 1'b0, 10'd0);     // link down: no decision
    send_poll(8'd100, 1'b1, 10'd1023);  // at the press threshold: no press
    send_poll(8'd101, 1'b1, 10'd1023);  // press; timer starts from zero
    send_poll(8'd90,  1'b1, 10'd0);     // at the release threshold: still held
    send_poll(8'd89,  1'b1, 10'd0);     // release after zero hold: no event
    send_poll(8'd255, 1'b1, 10'd0);
    send_poll(8'd128, 1'b0, 10'd1023);  // link down: timer runs, no page up yet
    send_poll(8'd200, 1'b1, 10'd0);     // page up
    send_poll(8'd0,   1'b1, 10'd0);     // release after long: no page down
    send_poll(8'd101, 1'b1, 10'd0);
    send_poll(8'd200, 1'b1, 10'd499);
    send_poll(8'd0,   1'b1, 10'd0);     // page down just under the limit
    send_poll(8'd150, 1'b1, 10'd0);
    send_poll(8'd150, 1'b1, 10'd500);   // page up exactly at the limit
    send_poll(8'd150, 1'b1, 10'd1023);  // only one page up per hold
    send_poll(8'd0,   1'b1, 10'd0);
    send_poll(8'd150, 1'b1, 10'd7);
    send_poll(8'd0,   1'b1, 10'd1);     // one ms hold: page down

    hold_req = 1'b1;
    random_polls(450);

    // Crossed thresholds and a zero long press: every press pages up at once.
    apply_settings(8'd0, 8'd255, 16'd0);
    hold_req = 1'b1;
    random_polls(650);

    // Widest limit: page up only once the timer saturates.
    apply_settings(8'd254, 8'd1, 16'hFFFF);
    send_poll(8'd255, 1'b1, 10'd0);
    repeat (65) send_poll(8'd200, 1'b1, 10'd1023);
    repeat (2) send_poll(8'd200, 1'b0, 10'd1023);
    send_poll(8'd0, 1'b1, 10'd0);
    random_polls(800);

    // No sample can press.
    apply_settings(8'd255, 8'd0, 16'd300);
    random_polls(880);

    // Back-to-back beats on both sides.
    apply_settings(8'd128, 8'd128, 16'd1023);
    no_idle = 1'b1;
    random_polls(1200);
    no_idle = 1'b0;

    while (polls_sent < 1950) begin
      apply_settings(SampleW'($urandom_range(255)), SampleW'($urandom_range(255)),
                     ($urandom_range(3) == 0) ? TimerW'($urandom_range(65535))
                                              : TimerW'($urandom_range(1500)));
      random_polls(polls_sent + 150);
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** pedal_short_long_press_detector: PASSED **");
    end else begin
      $display("** pedal_short_long_press_detector: FAILED **");
    end
    $finish;
  end

endmodule
